>>> rtl/core/rc_channel_window_averager_macros.svh
// assertion macros for the channel window averager
`ifndef RC_CHANNEL_WINDOW_AVERAGER_MACROS_SVH
`define RC_CHANNEL_WINDOW_AVERAGER_MACROS_SVH

`ifndef SYNTHESIS
`define RCWA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcwa: implication check failed");
`define RCWA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcwa: next cycle check failed");
`else
`define RCWA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RCWA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/rcwa_pkg.sv
`timescale 1ns / 1ps
package rcwa_pkg;

  localparam int WIDTH_W  = 16;
  localparam int SAMPLE_W = 17;
  localparam int COUNT_W  = 16;
  localparam int CH_W     = 3;

  localparam logic [WIDTH_W-1:0] ZERO_OFFSET_RST = 16'd1500;

endpackage

>>> rtl/core/rcwa_in_if.sv
`timescale 1ns / 1ps
interface rcwa_in_if;
  import rcwa_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] pulse_width;
  logic               timed_out;

  modport source (output valid, output pulse_width, output timed_out, input ready);
  modport sink   (input valid, input pulse_width, input timed_out, output ready);
endinterface

>>> rtl/core/rcwa_out_if.sv
`timescale 1ns / 1ps
interface rcwa_out_if;
  import rcwa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] average;
  logic                       window_full;
  logic [COUNT_W-1:0]         error_count;
  logic [CH_W-1:0]            next_channel;

  modport source (
    output valid, output channel, output sample, output average,
    output window_full, output error_count, output next_channel, input ready
  );
  modport sink (
    input valid, input channel, input sample, input average,
    input window_full, input error_count, input next_channel, output ready
  );
endinterface

>>> rtl/core/rcwa_ram.sv
`timescale 1ns / 1ps
module rcwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rc_channel_window_averager.sv
`timescale 1ns / 1ps
// Channel window averager for a multiplexed RC receiver.
// pulse_i carries one pulse measurement (width or timeout) for the channel
// currently on the multiplexer; result_o returns one record per measurement:
// channel, pushed sample, stored average, window_full, error count and the
// channel select to drive next. The user must write zero_offset through
// cfg_we_i / cfg_wdata_i while the block is idle; the block does not enforce it.
// One item at a time: pulse_i.ready is high only in the idle state.
// Without an average an item goes from S_IDLE through S_REC to S_DONE; with a
// full window S_REC is followed by S_SUM, which reads the channel's window
// slots, and S_DIV before S_DONE. A new item is taken in the idle state that
// follows the loading of the previous result. The long path is set by one
// window memory read per sample and a reciprocal multiply in S_DIV for the
// division by WINDOW_LEN.
// Reset clears the channel pointer, the per-channel record valid bits (so
// masks, averages and error counts read as zero) and loads zero_offset 1500.
// A result waits in the output register while result_o.ready is low; the
// next item may be taken and processed, stalling only at its final cycle.
`include "rc_channel_window_averager_macros.svh"
module rc_channel_window_averager #(
  parameter int CHANNELS   = 8,
  parameter int WINDOW_LEN = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcwa_pkg::WIDTH_W-1:0]  cfg_wdata_i,
  rcwa_in_if.sink                       pulse_i,
  rcwa_out_if.source                    result_o
);
  import rcwa_pkg::*;

  localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WDEPTH = CHANNELS * WINDOW_LEN;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int MASK_W = WINDOW_LEN;
  localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int AVG_W  = SAMPLE_W;
  localparam int REC_W  = MASK_W + PTR_W + AVG_W + COUNT_W;
  localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW_LEN);
  localparam int SCW    = $clog2(WINDOW_LEN + 1);
  localparam int DIV_SH = SUM_W + $clog2(WINDOW_LEN);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((1 << DIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam int AVG_LO = COUNT_W;
  localparam int PTR_LO = AVG_LO + AVG_W;
  localparam int MSK_LO = PTR_LO + PTR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_SUM,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;

  logic [WIDTH_W-1:0]         zero_offset_q;
  logic [CH_W-1:0]            cur_ch_q;
  logic [CH_W-1:0]            ch_q;
  logic [CH_W-1:0]            nxt_q;
  logic [CHANNELS-1:0]        rec_vld_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       timed_q;
  logic [MASK_W-1:0]          mask_q;
  logic [PTR_W-1:0]           ptr_q;
  logic [AVG_W-1:0]           avg_q;
  logic [COUNT_W-1:0]         cnt_q;
  logic                       full_q;
  logic [SCW-1:0]             sum_cnt_q;
  logic [SUM_W-1:0]           acc_q;
  logic                       neg_q;
  logic [SUM_W-1:0]           dq_q;

  logic                       out_vld_q;
  logic [CH_W-1:0]            out_ch_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic signed [SAMPLE_W-1:0] out_avg_q;
  logic                       out_full_q;
  logic [COUNT_W-1:0]         out_cnt_q;
  logic [CH_W-1:0]            out_nxt_q;

  logic                       in_xfer;
  logic [CH_W-1:0]            nxt_ch;
  logic signed [SAMPLE_W-1:0] sample_d;
  logic [CIW-1:0]             ch_idx;

  logic [REC_W-1:0]           rec_rdata;
  logic [REC_W-1:0]           rec_raw;
  logic [REC_W-1:0]           rec_wdata;
  logic                       rec_we;
  logic [MASK_W-1:0]          mask_old;
  logic [PTR_W-1:0]           ptr_old;
  logic [AVG_W-1:0]           avg_old;
  logic [COUNT_W-1:0]         cnt_old;
  logic [MASK_W-1:0]          mask_new;
  logic [PTR_W-1:0]           ptr_new;
  logic                       full_new;

  logic                       win_we;
  logic [WAW-1:0]             win_waddr;
  logic [WAW-1:0]             win_raddr;
  logic [SAMPLE_W-1:0]        win_rdata;
  logic [SUM_W-1:0]           acc_next;
  logic [SUM_W-1:0]           acc_mag;

  logic [PROD_W-1:0]          prod;
  logic [SUM_W-1:0]           q_final;
  logic [SUM_W-1:0]           q_signed;
  logic                       done_go;

  assign in_xfer  = pulse_i.valid && pulse_i.ready;
  assign nxt_ch   = (cur_ch_q == CH_W'(CHANNELS - 1)) ? '0 : cur_ch_q + CH_W'(1);
  assign sample_d = pulse_i.timed_out ? '0 :
                    signed'({1'b0, pulse_i.pulse_width} - {1'b0, zero_offset_q});
  assign ch_idx   = ch_q[CIW-1:0];

  // per-channel record: mask, window pointer, average, error count
  assign rec_raw  = rec_vld_q[ch_idx] ? rec_rdata : '0;
  assign mask_old = rec_raw[MSK_LO +: MASK_W];
  assign ptr_old  = rec_raw[PTR_LO +: PTR_W];
  assign avg_old  = rec_raw[AVG_LO +: AVG_W];
  assign cnt_old  = rec_raw[COUNT_W-1:0];
  assign mask_new = (mask_old >> 1) | (MASK_W'(!timed_q) << (WINDOW_LEN - 1));
  assign ptr_new  = (ptr_old == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_old + PTR_W'(1);
  assign full_new = !timed_q && (mask_new == '1);

  assign done_go   = (state_q == S_DONE) && (!out_vld_q || result_o.ready);
  assign rec_we    = done_go;
  assign rec_wdata = {mask_q, ptr_q, avg_q, cnt_q};

  // window write at the ring pointer, reads sweep the channel's slots
  assign win_we    = (state_q == S_REC);
  assign win_waddr = WAW'(int'(ch_q) * WINDOW_LEN + int'(ptr_old));
  assign win_raddr = (sum_cnt_q < SCW'(WINDOW_LEN)) ?
                     WAW'(int'(ch_q) * WINDOW_LEN + int'(sum_cnt_q)) :
                     WAW'(int'(ch_q) * WINDOW_LEN);
  assign acc_next  = acc_q + {{(SUM_W - SAMPLE_W){win_rdata[SAMPLE_W-1]}}, win_rdata};
  assign acc_mag   = acc_next[SUM_W-1] ? (~acc_next + SUM_W'(1)) : acc_next;

  // magnitude over window length by reciprocal multiply, exact for the sum range
  assign prod     = PROD_W'(dq_q) * PROD_W'(RECIP);
  assign q_final  = SUM_W'(prod >> DIV_SH);
  assign q_signed = neg_q ? (~q_final + SUM_W'(1)) : q_final;

  rcwa_ram #(
    .WIDTH (REC_W),
    .DEPTH (CHANNELS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (ch_idx),
    .wdata_i (rec_wdata),
    .raddr_i (cur_ch_q[CIW-1:0]),
    .rdata_o (rec_rdata)
  );

  rcwa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WDEPTH)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (sample_q),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      zero_offset_q <= ZERO_OFFSET_RST;
      cur_ch_q      <= '0;
      rec_vld_q     <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        zero_offset_q <= cfg_wdata_i;
      end
      if (out_vld_q && result_o.ready && !done_go) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            ch_q     <= cur_ch_q;
            nxt_q    <= nxt_ch;
            cur_ch_q <= nxt_ch;
            sample_q <= sample_d;
            timed_q  <= pulse_i.timed_out;
            state_q  <= S_REC;
          end
        end
        S_REC: begin
          mask_q    <= mask_new;
          ptr_q     <= ptr_new;
          avg_q     <= avg_old;
          cnt_q     <= cnt_old + COUNT_W'(timed_q);
          full_q    <= full_new;
          sum_cnt_q <= '0;
          acc_q     <= '0;
          state_q   <= full_new ? S_SUM : S_DONE;
        end
        S_SUM: begin
          if (sum_cnt_q == SCW'(WINDOW_LEN)) begin
            neg_q   <= acc_next[SUM_W-1];
            dq_q    <= acc_mag;
            state_q <= S_DIV;
          end else begin
            if (sum_cnt_q != '0) begin
              acc_q <= acc_next;
            end
            sum_cnt_q <= sum_cnt_q + SCW'(1);
          end
        end
        S_DIV: begin
          avg_q   <= q_signed[AVG_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (done_go) begin
            rec_vld_q[ch_idx] <= 1'b1;
            out_vld_q         <= 1'b1;
            out_ch_q          <= ch_q;
            out_sample_q      <= sample_q;
            out_avg_q         <= signed'(avg_q);
            out_full_q        <= full_q;
            out_cnt_q         <= cnt_q;
            out_nxt_q         <= nxt_q;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign pulse_i.ready        = (state_q == S_IDLE);
  assign result_o.valid       = out_vld_q;
  assign result_o.channel     = out_ch_q;
  assign result_o.sample      = out_sample_q;
  assign result_o.average     = out_avg_q;
  assign result_o.window_full = out_full_q;
  assign result_o.error_count = out_cnt_q;
  assign result_o.next_channel = out_nxt_q;

  `RCWA_ASSERT_NXT(a_xfer_starts_item, clk_i, rst_ni, in_xfer, state_q == S_REC)
  `RCWA_ASSERT_IMP(a_channel_range, clk_i, rst_ni, out_vld_q, int'(out_ch_q) < CHANNELS)
  `RCWA_ASSERT_IMP(a_next_range, clk_i, rst_ni, out_vld_q, int'(out_nxt_q) < CHANNELS)
  `RCWA_ASSERT_IMP(a_sum_bound, clk_i, rst_ni, state_q == S_SUM, sum_cnt_q <= SCW'(WINDOW_LEN))
  `RCWA_ASSERT_NXT(a_full_no_timeout, clk_i, rst_ni, (state_q == S_REC) && timed_q, !full_q)

endmodule

>>> sim/rcwa_average_checker.sv
`timescale 1ns / 1ps
module rcwa_average_checker
  import rcwa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIDTH_W-1:0] cfg_wdata_i,
  rcwa_in_if                 pulse_mon,
  rcwa_out_if                result_mon,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 averages_o,
  output int                 timeouts_o
);

  localparam int              NUM_CH   = 8;
  localparam int              WIN_LEN  = 4;
  localparam logic [3:0]      WIN_FULL = 4'hF;
  localparam logic [3:0]      WIN_NEW  = 4'h8;
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(NUM_CH - 1);

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] average;
    logic                window_full;
    logic [COUNT_W-1:0]  error_count;
    logic [CH_W-1:0]     next_channel;
  } avg_result_t;

  avg_result_t expected_q[$];

  logic [WIDTH_W-1:0] offset_q;
  logic [CH_W-1:0]    cur_ch;
  logic signed [17:0] win_mem [NUM_CH][WIN_LEN];
  logic [3:0]         good_mask [NUM_CH];
  logic signed [17:0] ch_avg [NUM_CH];
  logic [COUNT_W-1:0] tmo_cnt [NUM_CH];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  function automatic avg_result_t predict_pulse(input logic [WIDTH_W-1:0] w,
                                                input logic to);
    avg_result_t        r;
    logic signed [17:0] smp;
    int                 sum;
    int                 k;
    smp           = '0;
    r.window_full = 1'b0;
    for (k = 0; k < WIN_LEN - 1; k++) begin
      win_mem[cur_ch][k] = win_mem[cur_ch][k+1];
    end
    if (to) begin
      win_mem[cur_ch][WIN_LEN-1] = '0;
      good_mask[cur_ch]          = good_mask[cur_ch] >> 1;
      tmo_cnt[cur_ch]            = tmo_cnt[cur_ch] + 1'b1;
    end else begin
      smp = $signed({2'b00, w}) - $signed({2'b00, offset_q});
      win_mem[cur_ch][WIN_LEN-1] = smp;
      good_mask[cur_ch]          = (good_mask[cur_ch] >> 1) | WIN_NEW;
      if (good_mask[cur_ch] == WIN_FULL) begin
        sum = 0;
        for (k = 0; k < WIN_LEN; k++) begin
          sum += int'(win_mem[cur_ch][k]);
        end
        ch_avg[cur_ch] = 18'(sum / WIN_LEN);
        r.window_full  = 1'b1;
      end
    end
    r.channel     = cur_ch;
    r.sample      = smp[SAMPLE_W-1:0];
    r.average     = ch_avg[cur_ch][SAMPLE_W-1:0];
    r.error_count = tmo_cnt[cur_ch];
    cur_ch        = (cur_ch == CH_LAST) ? '0 : cur_ch + 1'b1;
    r.next_channel = cur_ch;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    avg_result_t got_r;
    avg_result_t exp_r;
    int          c;
    int          k;
    if (!rst_ni) begin
      offset_q = ZERO_OFFSET_RST;
      cur_ch   = '0;
      for (c = 0; c < NUM_CH; c++) begin
        for (k = 0; k < WIN_LEN; k++) begin
          win_mem[c][k] = '0;
        end
        good_mask[c] = '0;
        ch_avg[c]    = '0;
        tmo_cnt[c]   = '0;
      end
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      averages_o   = 0;
      timeouts_o   = 0;
    end else begin
      if (cfg_we_i) begin
        offset_q = cfg_wdata_i;
      end
      if (result_mon.valid && result_mon.ready) begin
        got_r.channel      = result_mon.channel;
        got_r.sample       = result_mon.sample;
        got_r.average      = result_mon.average;
        got_r.window_full  = result_mon.window_full;
        got_r.error_count  = result_mon.error_count;
        got_r.next_channel = result_mon.next_channel;
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with no expectation waiting");
        end else begin
          exp_r = expected_q.pop_front();
          check_field("channel", 32'(got_r.channel), 32'(exp_r.channel));
          check_field("sample", 32'(got_r.sample), 32'(exp_r.sample));
          check_field("average", 32'(got_r.average), 32'(exp_r.average));
          check_field("window_full", 32'(got_r.window_full), 32'(exp_r.window_full));
          check_field("error_count", 32'(got_r.error_count), 32'(exp_r.error_count));
          check_field("next_channel", 32'(got_r.next_channel), 32'(exp_r.next_channel));
          if (exp_r.window_full) begin
            averages_o++;
          end
        end
      end
      if (pulse_mon.valid && pulse_mon.ready) begin
        if (pulse_mon.timed_out) begin
          timeouts_o++;
        end
        expected_q.push_back(predict_pulse(pulse_mon.pulse_width, pulse_mon.timed_out));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> sim/tb_rc_channel_window_averager.sv
`timescale 1ns / 1ps
module tb_rc_channel_window_averager;
  import rcwa_pkg::*;

  localparam int          LIMIT_CYCLES = 200_000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          BURST_ITEMS  = 16;
  localparam logic [15:0] OFS_MIN      = 16'd0;
  localparam logic [15:0] OFS_MAX      = 16'd65535;
  localparam logic [15:0] OFS_CENTER   = 16'd1500;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [WIDTH_W-1:0] cfg_wdata;

  rcwa_in_if  pulse_if ();
  rcwa_out_if result_if ();

  int fail_count;
  int pending;
  int results;
  int averages;
  int timeouts;
  int cycles;
  int settings;

  bit                 idle_on;
  bit                 hold_req;
  logic [WIDTH_W-1:0] cur_offset;

  rc_channel_window_averager DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .pulse_i    (pulse_if),
    .result_o   (result_if)
  );

  rcwa_average_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pulse_mon   (pulse_if),
    .result_mon  (result_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .averages_o  (averages),
    .timeouts_o  (timeouts)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("rc_channel_window_averager regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        result_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(result_if.valid && result_if.ready)) @(posedge clk_i);
    end
  end

  task automatic send_pulse(input logic [WIDTH_W-1:0] w, input logic to);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      pulse_if.valid       <= 1'b0;
      pulse_if.pulse_width <= 16'($urandom);
      pulse_if.timed_out   <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pulse_if.valid       <= 1'b1;
    pulse_if.pulse_width <= w;
    pulse_if.timed_out   <= to;
    @(posedge clk_i);
    while (!(pulse_if.valid && pulse_if.ready)) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    pulse_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_offset(input logic [WIDTH_W-1:0] v);
    wait_drained();
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
    cur_offset = v;
    settings++;
  endtask

  function automatic logic [WIDTH_W-1:0] pick_width(input logic [WIDTH_W-1:0] ofs);
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 65535);
      1:       v = $urandom_range(0, 1) ? 65535 : 0;
      default: v = int'(ofs) + int'($urandom_range(0, 1200)) - 600;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic run_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_pulse(16'($urandom), 1'b1);
      end else begin
        send_pulse(pick_width(cur_offset), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    pulse_if.valid       = 1'b0;
    pulse_if.pulse_width = '0;
    pulse_if.timed_out   = 1'b0;
    idle_on              = 1'b1;
    hold_req             = 1'b0;
    cur_offset           = ZERO_OFFSET_RST;
    cycles               = 0;
    settings             = 1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset offset: one window per channel slot, channel 0 fills and wraps
    for (i = 0; i < 25; i++) begin
      case (i % 8)
        0: send_pulse(16'hFFFF, 1'b0);
        1: send_pulse(16'h0000, 1'b0);
        2: send_pulse(OFS_CENTER, 1'b0);
        3: send_pulse(16'hFFFF, 1'b1);
        4: send_pulse(OFS_CENTER + 16'd1, 1'b0);
        5: send_pulse(OFS_CENTER - 16'd1, 1'b0);
        6: send_pulse(16'($urandom), (i == 6) ? 1'b1 : 1'b0);
        default: send_pulse(16'($urandom), 1'b0);
      endcase
    end

    write_offset(OFS_MIN);
    run_random(64);

    write_offset(OFS_MAX);
    hold_req = 1'b1;
    run_random(64);

    write_offset(16'($urandom_range(1, 65534)));
    idle_on = 1'b0;
    run_random(64);
    idle_on = 1'b1;
    run_random(64);

    write_offset(OFS_CENTER);
    run_random(64);

    // back-to-back timeouts on every channel
    idle_on = 1'b0;
    for (i = 0; i < BURST_ITEMS; i++) begin
      send_pulse(16'($urandom), 1'b1);
    end
    idle_on = 1'b1;
    run_random(40);

    wait_drained();
    $display("covered %0d results, %0d full-window averages, %0d timeouts",
             results, averages, timeouts);
    $display("across %0d offset settings, including both extremes", settings);
    if (fail_count == 0 && pending == 0) begin
      $display("rc_channel_window_averager regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("rc_channel_window_averager regression: fail");
    end
    $finish;
  end

endmodule

>>> rc_channel_window_averager.f
+incdir+rtl/core
rtl/core/rcwa_pkg.sv
rtl/core/rcwa_in_if.sv
rtl/core/rcwa_out_if.sv
rtl/core/rcwa_ram.sv
rtl/core/rc_channel_window_averager.sv
sim/rcwa_average_checker.sv
sim/tb_rc_channel_window_averager.sv
